/* hw/rtl/matrix4_multiply_defines.svh */
// ----------------------------------------------------------------------------
// matrix4_multiply assertion macros
// shared concurrent assertion forms for the matrix multiply block
// ----------------------------------------------------------------------------
`ifndef MATRIX4_MULTIPLY_DEFINES_SVH
`define MATRIX4_MULTIPLY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MM4_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix4_multiply: same-cycle check failed");

// next-cycle implication, disabled during reset
`define MM4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix4_multiply: next-cycle check failed");

`endif

/* hw/rtl/mm4_pkg.sv */
// ----------------------------------------------------------------------------
// mm4_pkg
// types and constants shared by the matrix multiply front, queue and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mm4_pkg;

   localparam int MATRIX_DIM_DEFAULT    = 4;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int MODE_W = 2;
   localparam int IDX_W  = 4;
   localparam int VAL_W  = 32;

   localparam logic [MODE_W-1:0] MODE_LOAD_LEFT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_RIGHT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MULTIPLY   = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QA_W        = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CMD_LOAD_LEFT,
      CMD_LOAD_RIGHT,
      CMD_MULTIPLY
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [IDX_W-1:0]  addr;
      logic [VAL_W-1:0]  value;
   } queue_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WAIT
   } back_state_type;

endpackage

/* hw/rtl/mm4_front.sv */
// ----------------------------------------------------------------------------
// mm4_front
// accepts requests, decodes the mode and drops unused modes and indexes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mm4_front
   import mm4_pkg::*;
#(
   parameter int MATRIX_DIM = MATRIX_DIM_DEFAULT
) (
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [IDX_W-1:0]        req_element_index,
   input  logic signed [VAL_W-1:0] req_element_value,
   input  logic                    queue_full,
   output logic                    push,
   output queue_entry_type         push_entry
);

   localparam int CELLS = MATRIX_DIM * MATRIX_DIM;

   logic keep;
   logic in_range;

   assign in_range = 32'(req_element_index) < CELLS;

   always_comb begin
      keep             = 1'b0;
      push_entry.cmd   = CMD_MULTIPLY;
      push_entry.addr  = req_element_index;
      push_entry.value = req_element_value;
      case (req_mode)
         MODE_LOAD_LEFT: begin
            keep           = in_range;
            push_entry.cmd = CMD_LOAD_LEFT;
         end
         MODE_LOAD_RIGHT: begin
            keep           = in_range;
            push_entry.cmd = CMD_LOAD_RIGHT;
         end
         MODE_MULTIPLY: begin
            keep           = 1'b1;
            push_entry.cmd = CMD_MULTIPLY;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // dropped requests are still accepted, they just never reach the queue
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full && keep;

endmodule

/* hw/rtl/mm4_queue.sv */
// ----------------------------------------------------------------------------
// mm4_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix4_multiply_defines.svh"

module mm4_queue
   import mm4_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output logic            empty,
   output logic            full
);

   queue_entry_type q_mem [QUEUE_DEPTH];

   logic [QA_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QA_W:0]   count_ff,  count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QA_W+1)'(QUEUE_DEPTH));
   assign head  = q_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QA_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QA_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_entry;
      end
   end

   `MM4_ASSERT_NOW(a_no_push_full, clock, reset, full, !push)
   `MM4_ASSERT_NOW(a_no_pop_empty, clock, reset, empty, !pop)
   `MM4_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= (QA_W+1)'(QUEUE_DEPTH))

endmodule

/* hw/rtl/mm4_back.sv */
// ----------------------------------------------------------------------------
// mm4_back
// matrix stores, shared multiply-accumulate unit and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix4_multiply_defines.svh"

module mm4_back
   import mm4_pkg::*;
#(
   parameter int MATRIX_DIM    = MATRIX_DIM_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  queue_entry_type         head,
   input  logic                    queue_empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_result_index,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic                    rsp_saturated,
   output logic                    rsp_last
);

   localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
   localparam int CIDX  = $clog2(CELLS);
   localparam int DW    = $clog2(MATRIX_DIM);
   localparam int PROD_W = 2 * VAL_W;
   localparam int ACC_W = PROD_W + $clog2(MATRIX_DIM);

   back_state_type state_ff, state_in;

   logic [VAL_W-1:0] left_mem  [CELLS];
   logic [VAL_W-1:0] right_mem [CELLS];
   logic [CELLS-1:0] left_vld_ff, right_vld_ff;

   logic [DW-1:0]   row_ff, row_in;
   logic [DW-1:0]   col_ff, col_in;
   logic [DW-1:0]   k_ff, k_in;
   logic [CIDX-1:0] pos_ff, pos_in;

   logic [CIDX-1:0] left_addr, right_addr, wr_addr;
   logic            issue, load_out, out_free;
   logic            k_end, pos_end;

   logic [VAL_W-1:0] left_rd_ff, right_rd_ff;
   logic             left_ok_ff, right_ok_ff;
   logic             s1_vld_ff, s1_first_ff, s1_last_ff;
   logic signed [VAL_W-1:0]  a_op, b_op;
   logic signed [PROD_W-1:0] prod_ff;
   logic             s2_vld_ff, s2_first_ff, s2_last_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic             done_ff, done_in;

   logic signed [ACC_W-1:0] shifted;
   logic [ACC_W-32:0]       upper;
   logic                    clip;
   logic [VAL_W-1:0]        sat_value;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_index_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic                    rsp_sat_ff, rsp_last_ff;

   assign k_end     = (k_ff == DW'(MATRIX_DIM-1));
   assign pos_end   = (pos_ff == CIDX'(CELLS-1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign left_addr  = CIDX'(row_ff) + CIDX'(k_ff) * CIDX'(MATRIX_DIM);
   assign right_addr = CIDX'(k_ff) + CIDX'(col_ff) * CIDX'(MATRIX_DIM);
   assign wr_addr    = CIDX'(head.addr);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty && head.cmd == CMD_MULTIPLY) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (k_end) begin
               state_in = BK_WAIT;
            end
         end
         BK_WAIT: begin
            if (done_ff && out_free) begin
               state_in = pos_end ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      pop      = 1'b0;
      issue    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE:  pop      = !queue_empty;
         BK_READ:  issue    = 1'b1;
         BK_WAIT:  load_out = done_ff && out_free;
         default:  pop      = 1'b0;
      endcase
   end

   // element counters, column outer and row inner
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      k_in   = k_ff;
      pos_in = pos_ff;
      if (pop) begin
         row_in = '0;
         col_in = '0;
         k_in   = '0;
         pos_in = '0;
      end else if (issue) begin
         k_in = k_end ? '0 : k_ff + 1'b1;
      end else if (load_out) begin
         pos_in = pos_ff + 1'b1;
         if (row_ff == DW'(MATRIX_DIM-1)) begin
            row_in = '0;
            col_in = col_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         k_ff     <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         k_ff     <= k_in;
         pos_ff   <= pos_in;
      end
   end

   // stores: entries never written read as zero through the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         left_vld_ff  <= '0;
         right_vld_ff <= '0;
      end else if (pop && head.cmd == CMD_LOAD_LEFT) begin
         left_vld_ff[wr_addr] <= 1'b1;
      end else if (pop && head.cmd == CMD_LOAD_RIGHT) begin
         right_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.cmd == CMD_LOAD_LEFT) begin
         left_mem[wr_addr] <= head.value;
      end
      left_rd_ff <= left_mem[left_addr];
      left_ok_ff <= left_vld_ff[left_addr];
   end

   always_ff @(posedge clock) begin
      if (pop && head.cmd == CMD_LOAD_RIGHT) begin
         right_mem[wr_addr] <= head.value;
      end
      right_rd_ff <= right_mem[right_addr];
      right_ok_ff <= right_vld_ff[right_addr];
   end

   assign a_op = left_ok_ff  ? $signed(left_rd_ff)  : '0;
   assign b_op = right_ok_ff ? $signed(right_rd_ff) : '0;

   // accumulate; the sum restarts on the first term of each element
   always_comb begin
      acc_in  = acc_ff;
      done_in = done_ff;
      if (s2_vld_ff) begin
         acc_in = (s2_first_ff ? '0 : acc_ff) +
                  $signed({{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
         if (s2_last_ff) begin
            done_in = 1'b1;
         end
      end else if (load_out) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (k_ff == '0);
      s1_last_ff  <= k_end;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= a_op * b_op;
      acc_ff      <= acc_in;
   end

   // shift out the fraction and clip to 32 bits
   assign shifted = acc_ff >>> FRACTION_BITS;
   assign upper   = shifted[ACC_W-1:VAL_W-1];
   assign clip    = !((&upper) || !(|upper));

   always_comb begin
      if (!clip) begin
         sat_value = shifted[VAL_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         sat_value = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_index_ff <= IDX_W'(pos_ff);
         rsp_value_ff <= $signed(sat_value);
         rsp_sat_ff   <= clip;
         rsp_last_ff  <= pos_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_last         = rsp_last_ff;

   `MM4_ASSERT_NOW(a_done_only_waiting, clock, reset, done_ff, state_ff == BK_WAIT)
   `MM4_ASSERT_NOW(a_idle_drained, clock, reset, state_ff == BK_IDLE,
                   !s1_vld_ff && !s2_vld_ff && !done_ff)
   `MM4_ASSERT_NEXT(a_load_shows, clock, reset, load_out, rsp_valid_ff)

endmodule

/* hw/rtl/matrix4_multiply.sv */
// ----------------------------------------------------------------------------
// matrix4_multiply
// load requests are written into their store as the back unit pops them
// a multiply emits MATRIX_DIM*MATRIX_DIM results, computed one at a time
// by the single multiply-accumulate unit; the next waits for a free output
// requests are accepted while the four-entry queue has room
// synchronous reset empties the queue; both stores then read as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix4_multiply
   import mm4_pkg::*;
#(
   parameter int MATRIX_DIM    = MATRIX_DIM_DEFAULT,
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [IDX_W-1:0]        req_element_index,
   input  logic signed [VAL_W-1:0] req_element_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rsp_result_index,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic                    rsp_saturated,
   output logic                    rsp_last
);

   logic            push, pop, q_empty, q_full;
   queue_entry_type push_entry, head;

   mm4_front #(
      .MATRIX_DIM (MATRIX_DIM)
   ) u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .queue_full        (q_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   mm4_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   mm4_back #(
      .MATRIX_DIM    (MATRIX_DIM),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .queue_empty      (q_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value),
      .rsp_saturated    (rsp_saturated),
      .rsp_last         (rsp_last)
   );

endmodule
